/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define TMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define TMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/tms_pkg.sv */
`timescale 1ns / 1ps

package tms_pkg;

  localparam int MAX_NOTES = 64;
  localparam int POS_W     = $clog2(MAX_NOTES);
  localparam int LEN_W     = $clog2(MAX_NOTES + 1);

  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_WRITE  = 3'd1;
  localparam logic [2:0] MODE_MELODY = 3'd2;
  localparam logic [2:0] MODE_TONE   = 3'd3;
  localparam logic [2:0] MODE_STOP   = 3'd4;

  typedef struct packed {
    logic [2:0]  mode;
    logic [5:0]  note_slot;
    logic [6:0]  note_key;
    logic [15:0] note_on_ms;
    logic [15:0] note_gap_ms;
    logic [15:0] tone_freq_hz;
    logic        tone_from_key;
    logic [31:0] tone_ms;
    logic [7:0]  volume;
    logic [6:0]  note_count;
    logic        repeat_flag;
  } tms_item_t;

  typedef struct packed {
    logic [15:0] pwm_freq_hz;
    logic [6:0]  pwm_duty;
    logic        playing;
    logic [5:0]  note_position;
  } tms_result_t;

  // floor(440 * 2^((k-69)/12)) in whole Hz
  localparam logic [15:0] KEY_HZ [128] = '{
    16'd8, 16'd8, 16'd9, 16'd9, 16'd10, 16'd10, 16'd11, 16'd12,
    16'd12, 16'd13, 16'd14, 16'd15, 16'd16, 16'd17, 16'd18, 16'd19,
    16'd20, 16'd21, 16'd23, 16'd24, 16'd25, 16'd27, 16'd29, 16'd30,
    16'd32, 16'd34, 16'd36, 16'd38, 16'd41, 16'd43, 16'd46, 16'd48,
    16'd51, 16'd55, 16'd58, 16'd61, 16'd65, 16'd69, 16'd73, 16'd77,
    16'd82, 16'd87, 16'd92, 16'd97, 16'd103, 16'd110, 16'd116, 16'd123,
    16'd130, 16'd138, 16'd146, 16'd155, 16'd164, 16'd174, 16'd184, 16'd195,
    16'd207, 16'd220, 16'd233, 16'd246, 16'd261, 16'd277, 16'd293, 16'd311,
    16'd329, 16'd349, 16'd369, 16'd391, 16'd415, 16'd440, 16'd466, 16'd493,
    16'd523, 16'd554, 16'd587, 16'd622, 16'd659, 16'd698, 16'd739, 16'd783,
    16'd830, 16'd880, 16'd932, 16'd987, 16'd1046, 16'd1108, 16'd1174, 16'd1244,
    16'd1318, 16'd1396, 16'd1479, 16'd1567, 16'd1661, 16'd1760, 16'd1864, 16'd1975,
    16'd2093, 16'd2217, 16'd2349, 16'd2489, 16'd2637, 16'd2793, 16'd2959, 16'd3135,
    16'd3322, 16'd3520, 16'd3729, 16'd3951, 16'd4186, 16'd4434, 16'd4698, 16'd4978,
    16'd5274, 16'd5587, 16'd5919, 16'd6271, 16'd6644, 16'd7040, 16'd7458, 16'd7902,
    16'd8372, 16'd8869, 16'd9397, 16'd9956, 16'd10548, 16'd11175, 16'd11839, 16'd12543
  };

  function automatic logic [15:0] key_hz_of(input logic [6:0] key);
    return KEY_HZ[key];
  endfunction

  // vol*127/255; x/255 == (x + (x>>8) + 1) >> 8 while x/255 < 256
  function automatic logic [6:0] duty_of(input logic [7:0] vol);
    logic [14:0] prod;
    logic [15:0] sum;
    prod = 15'(vol) * 15'd127;
    sum  = 16'(prod) + 16'(prod >> 8) + 16'd1;
    return sum[14:8];
  endfunction

endpackage

/* rtl/core/tone_melody_sequencer.sv */
`timescale 1ns / 1ps
// An accepted item word is held in the input register, then executed into the result register once it is free.
// Throughput: one item word per cycle; result holding under backpressure stalls the input.
// The note table RAMs are read ahead, addressed from the next state, so reads never stall.
// Reset (rst, synchronous, active high): idle, silent, frequency 0, enable set to 1.
// Note table contents are not cleared by reset; unwritten entries read as garbage.

module tone_melody_sequencer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  tms_pkg::tms_item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output tms_pkg::tms_result_t result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);

  import tms_pkg::*;

  // ---------------------------------------------------------------------
  // Input register and result register
  // ---------------------------------------------------------------------
  logic        in_valid;
  tms_item_t   in_q;
  logic        out_valid;
  tms_result_t out_q;
  logic        proc;   // the held item word is executed this cycle

  assign proc       = in_valid && (!out_valid || result_ready);
  assign item_ready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_ready) begin
      in_valid <= item_valid;
    end
    if (item_valid && item_ready) begin
      in_q <= item;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------
  logic             enable;
  logic             active, active_next;
  logic             melody_mode, melody_mode_next;
  logic             in_gap, in_gap_next;
  logic             looping, looping_next;
  logic [POS_W-1:0] position, position_next;
  logic [LEN_W-1:0] melody_length, melody_length_next;
  logic [7:0]       melody_volume, melody_volume_next;
  logic [15:0]      phase_elapsed, phase_elapsed_next;
  logic [31:0]      tone_elapsed, tone_elapsed_next;
  logic [31:0]      tone_length, tone_length_next;
  logic [15:0]      freq_reg, freq_reg_next;
  logic [6:0]       duty_reg, duty_reg_next;
  logic [6:0]       key0;  // copy of entry 0's key, so a melody start needs no RAM read

  // ---------------------------------------------------------------------
  // Note table: times in one RAM (read at the current note), keys in a
  // second RAM (read at the note that follows). Both ports are addressed
  // from the next state so data lines up with the next item word. A write
  // to the address being read is forwarded for one cycle.
  // ---------------------------------------------------------------------
  logic             tbl_we;
  logic [POS_W-1:0] addr_cur, addr_follow;
  logic [LEN_W-1:0] pos_next_inc;
  logic [31:0]      rd_times;
  logic [6:0]       rd_key;
  logic             byp_times, byp_key;
  logic [31:0]      wr_times_q;
  logic [6:0]       wr_key_q;
  logic [15:0]      ent_on, ent_gap;
  logic [6:0]       ent_key;

  assign pos_next_inc = {1'b0, position_next} + LEN_W'(1);
  assign addr_cur     = position_next;
  assign addr_follow  = (pos_next_inc >= melody_length_next) ? '0 : pos_next_inc[POS_W-1:0];

  tms_ram #(.WIDTH(32), .DEPTH(MAX_NOTES)) u_times_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (in_q.note_slot),
    .wdata ({in_q.note_on_ms, in_q.note_gap_ms}),
    .raddr (addr_cur),
    .rdata (rd_times)
  );

  tms_ram #(.WIDTH(7), .DEPTH(MAX_NOTES)) u_key_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (in_q.note_slot),
    .wdata (in_q.note_key),
    .raddr (addr_follow),
    .rdata (rd_key)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_times <= 1'b0;
      byp_key   <= 1'b0;
    end else begin
      byp_times <= tbl_we && (in_q.note_slot == addr_cur);
      byp_key   <= tbl_we && (in_q.note_slot == addr_follow);
    end
    wr_times_q <= {in_q.note_on_ms, in_q.note_gap_ms};
    wr_key_q   <= in_q.note_key;
    if (tbl_we && in_q.note_slot == '0) begin
      key0 <= in_q.note_key;
    end
  end

  assign {ent_on, ent_gap} = byp_times ? wr_times_q : rd_times;
  assign ent_key           = byp_key ? wr_key_q : rd_key;

  // ---------------------------------------------------------------------
  // Per-word datapath
  // ---------------------------------------------------------------------
  logic [31:0]      tone_inc;
  logic [15:0]      phase_inc;
  logic [LEN_W-1:0] pos_inc;
  logic [15:0]      tone_hz;
  logic [15:0]      hz_key0, hz_follow;
  logic [6:0]       duty_item, duty_mel;
  logic             advance;

  assign tone_inc  = (tone_elapsed == '1) ? tone_elapsed : tone_elapsed + 32'd1;
  assign phase_inc = (phase_elapsed == '1) ? phase_elapsed : phase_elapsed + 16'd1;
  assign pos_inc   = {1'b0, position} + LEN_W'(1);
  assign hz_key0   = key_hz_of(key0);
  assign hz_follow = key_hz_of(ent_key);
  assign duty_item = duty_of(in_q.volume);
  assign duty_mel  = duty_of(melody_volume);
  // key 0 means rest, which looks like a zero frequency
  assign tone_hz   = !in_q.tone_from_key ? in_q.tone_freq_hz :
                     (in_q.note_key == '0) ? 16'd0 : key_hz_of(in_q.note_key);

  always_comb begin
    active_next        = active;
    melody_mode_next   = melody_mode;
    in_gap_next        = in_gap;
    looping_next       = looping;
    position_next      = position;
    melody_length_next = melody_length;
    melody_volume_next = melody_volume;
    phase_elapsed_next = phase_elapsed;
    tone_elapsed_next  = tone_elapsed;
    tone_length_next   = tone_length;
    freq_reg_next      = freq_reg;
    duty_reg_next      = duty_reg;
    tbl_we             = 1'b0;
    advance            = 1'b0;

    if (proc) begin
      case (in_q.mode)
        MODE_TICK: begin
          if (active && !melody_mode) begin
            // single tone: length 0 plays until stopped
            tone_elapsed_next = tone_inc;
            if (tone_length != '0 && tone_inc >= tone_length) begin
              active_next      = 1'b0;
              melody_mode_next = 1'b0;
              in_gap_next      = 1'b0;
              duty_reg_next    = '0;
            end
          end else if (active) begin
            phase_elapsed_next = phase_inc;
            if (in_gap) begin
              // gap compares against the live table entry
              advance = (phase_inc >= ent_gap);
            end else if (phase_inc >= ent_on) begin
              duty_reg_next = '0;
              if (ent_gap != '0) begin
                in_gap_next        = 1'b1;
                phase_elapsed_next = '0;
              end else begin
                advance = 1'b1;
              end
            end
          end
        end
        MODE_WRITE: begin
          tbl_we = 1'b1;
        end
        MODE_MELODY: begin
          if (enable && in_q.note_count != '0) begin
            melody_length_next = (in_q.note_count > LEN_W'(MAX_NOTES)) ?
                                 LEN_W'(MAX_NOTES) : in_q.note_count;
            melody_volume_next = in_q.volume;
            looping_next       = in_q.repeat_flag;
            melody_mode_next   = 1'b1;
            active_next        = 1'b1;
            position_next      = '0;
            in_gap_next        = 1'b0;
            phase_elapsed_next = '0;
            if (key0 == '0 || in_q.volume == '0) begin
              duty_reg_next = '0;
            end else begin
              freq_reg_next = hz_key0;
              duty_reg_next = duty_item;
            end
          end
        end
        MODE_TONE: begin
          if (enable) begin
            melody_mode_next  = 1'b0;
            active_next       = 1'b1;
            in_gap_next       = 1'b0;
            tone_elapsed_next = '0;
            tone_length_next  = in_q.tone_ms;
            if (tone_hz == '0 || in_q.volume == '0) begin
              duty_reg_next = '0;
            end else begin
              freq_reg_next = tone_hz;
              duty_reg_next = duty_item;
            end
          end
        end
        MODE_STOP: begin
          active_next      = 1'b0;
          melody_mode_next = 1'b0;
          in_gap_next      = 1'b0;
          duty_reg_next    = '0;
        end
        default: begin
        end
      endcase

      // step to the next note; key comes from the follow-on RAM port
      if (advance) begin
        if (pos_inc >= melody_length && !looping) begin
          active_next      = 1'b0;
          melody_mode_next = 1'b0;
          in_gap_next      = 1'b0;
          duty_reg_next    = '0;
        end else begin
          position_next      = (pos_inc >= melody_length) ? '0 : pos_inc[POS_W-1:0];
          in_gap_next        = 1'b0;
          phase_elapsed_next = '0;
          if (ent_key == '0 || melody_volume == '0) begin
            duty_reg_next = '0;
          end else begin
            freq_reg_next = hz_follow;
            duty_reg_next = duty_mel;
          end
        end
      end
    end

    // clearing enable also stops playback
    if (cfg_valid && !cfg_data) begin
      active_next      = 1'b0;
      melody_mode_next = 1'b0;
      in_gap_next      = 1'b0;
      duty_reg_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b1;
      active        <= 1'b0;
      melody_mode   <= 1'b0;
      in_gap        <= 1'b0;
      looping       <= 1'b0;
      position      <= '0;
      melody_length <= '0;
      melody_volume <= '0;
      phase_elapsed <= '0;
      tone_elapsed  <= '0;
      tone_length   <= '0;
      freq_reg      <= '0;
      duty_reg      <= '0;
    end else begin
      if (cfg_valid) begin
        enable <= cfg_data;
      end
      active        <= active_next;
      melody_mode   <= melody_mode_next;
      in_gap        <= in_gap_next;
      looping       <= looping_next;
      position      <= position_next;
      melody_length <= melody_length_next;
      melody_volume <= melody_volume_next;
      phase_elapsed <= phase_elapsed_next;
      tone_elapsed  <= tone_elapsed_next;
      tone_length   <= tone_length_next;
      freq_reg      <= freq_reg_next;
      duty_reg      <= duty_reg_next;
    end
  end

  // ---------------------------------------------------------------------
  // Result word: state as it stands after the item word
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= 1'b1;
    end else if (result_ready) begin
      out_valid <= 1'b0;
    end
    if (proc) begin
      out_q.pwm_freq_hz   <= freq_reg_next;
      out_q.pwm_duty      <= duty_reg_next;
      out_q.playing       <= active_next;
      out_q.note_position <= (active_next && melody_mode_next) ? 6'(position_next) : 6'd0;
    end
  end

  assign result_valid = out_valid;
  assign result       = out_q;
  assign cfg_ready    = 1'b1;

endmodule

/* rtl/core/tms_ram.sv */
`timescale 1ns / 1ps

module tms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/tms_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tms_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_ready,
  input logic                 result_valid,
  input logic                 result_ready,
  input tms_pkg::tms_result_t result
);

  import tms_pkg::*;

  `TMS_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result), "result word changed while stalled")
  `TMS_ASSERT(a_duty_needs_play, result_valid && result.pwm_duty != '0 |-> result.playing, "sound reported while idle")
  `TMS_ASSERT(a_pos_needs_play, result_valid && !result.playing |-> result.note_position == '0, "note position set while idle")
  `TMS_ASSERT(a_ready_when_free, !result_valid |-> item_ready, "input blocked with empty result register")
  `TMS_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid, "result word present after reset")

endmodule

bind tone_melody_sequencer tms_checker u_tms_checker (.*);
